// ===== rtl/gn2d_pkg.sv =====
package gn2d_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PIX_W = 16;
	localparam int CFG_W = 16;
	localparam int IDX_W = 2;
	localparam int MAXV_W = 8;
	localparam int CELL_W = 8;
	localparam int OUT_W = 24;
	localparam int GRAD_DIAG = 46341;
	localparam int GRAD_SHIFT = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_W-1:0] CELL_SIZE_RST = 16'd16;
	localparam logic [MAXV_W-1:0] MAX_VALUE_RST = 8'd255;
	localparam logic [CFG_W-1:0] SCALE_RST = 16'd256;

	typedef enum logic [IDX_W-1:0] {
		REG_CELL_SIZE = 2'd0,
		REG_MAX_VALUE = 2'd1,
		REG_SCALE     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] g00;
		logic [2:0] g10;
		logic [2:0] g01;
		logic [2:0] g11;
	} corner_t;

	localparam int CORNER_W = $bits(corner_t);

	localparam logic [7:0] PERM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
		8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
		8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
		8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
		8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
		8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
		8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
		8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
		8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
		8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
		8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
		8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
		8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
		8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
		8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
		8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
		8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
		8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
		8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
		8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
		8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
		8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

endpackage

// ===== rtl/gn2d_div.sv =====
module gn2d_div #(
	parameter int COORD_BITS = gn2d_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [COORD_BITS-1:0]         dividend,
	input  logic [gn2d_pkg::CFG_W-1:0]    divisor,
	output logic [gn2d_pkg::CELL_W-1:0]   cell_idx,
	output logic [FRAC_BITS-1:0]          frac
);

	localparam int N = COORD_BITS + FRAC_BITS;
	localparam int RW = gn2d_pkg::CFG_W + 1;
	localparam int QW = gn2d_pkg::CELL_W;

	logic [RW-1:0] dsr;
	logic [RW-2:0] rem_s [N];
	logic [RW-2:0] rem_i [N];
	logic [RW-2:0] rem_n [N];
	logic [COORD_BITS-1:0] dvd_s [N];
	logic [COORD_BITS-1:0] dvd_i [N];
	logic [COORD_BITS-1:0] dvd_n [N];
	logic [QW-1:0] quo_s [N];
	logic [QW-1:0] quo_i [N];
	logic [QW-1:0] quo_n [N];
	logic [FRAC_BITS-1:0] frac_s [N];
	logic [FRAC_BITS-1:0] frac_i [N];
	logic [FRAC_BITS-1:0] frac_n [N];

	// zero cell size acts as one
	assign dsr = (divisor == '0) ? RW'(1) : {1'b0, divisor};

	always_comb begin
		rem_i[0] = '0;
		dvd_i[0] = dividend;
		quo_i[0] = '0;
		frac_i[0] = '0;
		for (int k = 1; k < N; k++) begin
			rem_i[k] = rem_s[k-1];
			dvd_i[k] = dvd_s[k-1];
			quo_i[k] = quo_s[k-1];
			frac_i[k] = frac_s[k-1];
		end
	end

	// one restoring step per stage, integer bits first then fraction bits
	always_comb begin
		logic [RW-1:0] sh;
		logic [RW-1:0] df;
		logic ge;
		for (int k = 0; k < N; k++) begin
			sh = {rem_i[k], (k < COORD_BITS) ? dvd_i[k][COORD_BITS-1] : 1'b0};
			df = sh - dsr;
			ge = (sh >= dsr);
			rem_n[k] = ge ? df[RW-2:0] : sh[RW-2:0];
			dvd_n[k] = dvd_i[k] << 1;
			if (k < COORD_BITS) begin
				quo_n[k] = {quo_i[k][QW-2:0], ge};
				frac_n[k] = frac_i[k];
			end else begin
				quo_n[k] = quo_i[k];
				frac_n[k] = {frac_i[k][FRAC_BITS-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_n[k];
				dvd_s[k] <= dvd_n[k];
				quo_s[k] <= quo_n[k];
				frac_s[k] <= frac_n[k];
			end
		end
	end

	assign cell_idx = quo_s[N-1];
	assign frac = frac_s[N-1];

endmodule

// ===== rtl/gn2d_front.sv =====
module gn2d_front #(
	parameter int COORD_BITS = gn2d_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [gn2d_pkg::PIX_W-1:0]    pixel_x,
	input  logic [gn2d_pkg::PIX_W-1:0]    pixel_y,
	output logic                          full,
	input  logic [gn2d_pkg::CFG_W-1:0]    cell_size,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [FRAC_BITS-1:0]          fx,
	output logic [FRAC_BITS-1:0]          fy,
	output gn2d_pkg::corner_t             corners
);

	localparam int NV = COORD_BITS + FRAC_BITS + 2;

	logic [NV-1:0] vld_q;
	logic adv;
	logic [gn2d_pkg::CELL_W-1:0] cx, cy, cx_s1, pj0_s1, pj1_s1;
	logic [FRAC_BITS-1:0] dfx, dfy, fx_s1, fy_s1, fx_s2, fy_s2;
	gn2d_pkg::corner_t crn_s2;

	assign adv = !vld_q[NV-1] || !q_full;
	assign full = !adv;
	assign q_push = vld_q[NV-1] && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NV-2:0], push};
		end
	end

	gn2d_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .en(adv), .dividend(COORD_BITS'(pixel_x)), .divisor(cell_size),
		.cell_idx(cx), .frac(dfx)
	);

	gn2d_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .en(adv), .dividend(COORD_BITS'(pixel_y)), .divisor(cell_size),
		.cell_idx(cy), .frac(dfy)
	);

	// corner hashes over two table lookups
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1 <= cx;
			pj0_s1 <= gn2d_pkg::PERM[cy];
			pj1_s1 <= gn2d_pkg::PERM[cy + 8'd1];
			fx_s1 <= dfx;
			fy_s1 <= dfy;
			crn_s2.g00 <= gn2d_pkg::PERM[cx_s1 + pj0_s1][2:0];
			crn_s2.g10 <= gn2d_pkg::PERM[cx_s1 + 8'd1 + pj0_s1][2:0];
			crn_s2.g01 <= gn2d_pkg::PERM[cx_s1 + pj1_s1][2:0];
			crn_s2.g11 <= gn2d_pkg::PERM[cx_s1 + 8'd1 + pj1_s1][2:0];
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
		end
	end

	assign fx = fx_s2;
	assign fy = fy_s2;
	assign corners = crn_s2;

endmodule

// ===== rtl/gn2d_queue.sv =====
module gn2d_queue #(
	parameter int W = 44
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int D = gn2d_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(D);

	logic [W-1:0] mem_q [D];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(D));
	assign empty = (cnt_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("request pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("request popped from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(D))
		else $error("queue count out of range");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + (AW+1)'(1))
		else $error("queue count missed a push");

endmodule

// ===== rtl/gn2d_back.sv =====
module gn2d_back #(
	parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	output logic                               q_pop,
	input  logic [FRAC_BITS-1:0]               fx,
	input  logic [FRAC_BITS-1:0]               fy,
	input  gn2d_pkg::corner_t                  corners,
	input  logic [gn2d_pkg::MAXV_W-1:0]        max_value,
	input  logic [gn2d_pkg::CFG_W-1:0]         scale,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [gn2d_pkg::OUT_W-1:0]  noise_value
);

	localparam int F = FRAC_BITS;
	localparam int NB = 9;
	localparam int SW = F + 3;
	localparam int VW = SW + 17;
	localparam int DW = F + 2;
	localparam int WW = F + 2;
	localparam int LW = F + 3;
	localparam int NW = F + 4;
	localparam int P1W = NW + gn2d_pkg::MAXV_W + 1;
	localparam int PW = P1W + gn2d_pkg::CFG_W + 1;
	localparam int SHW = PW - F - 1;
	localparam logic signed [SHW-1:0] SAT_HI = SHW'(8388607);
	localparam logic signed [SHW-1:0] SAT_LO = SHW'(-8388608);

	logic [NB-1:0] vb_q;
	logic adv;

	logic signed [SW-1:0] sum_c [4];
	logic diag_c [4];
	logic [F-1:0] f2x_c, f2y_c, f3x_c, f3y_c;
	logic signed [DW-1:0] dot_c [4];
	logic [WW-1:0] wx_c, wy_c;
	logic signed [LW-1:0] l1_c, l2_c;
	logic signed [NW-1:0] n_c;
	logic signed [gn2d_pkg::OUT_W-1:0] res_c;

	logic signed [SW-1:0] sum_s1 [4];
	logic diag_s1 [4];
	logic [F-1:0] fx_s1, fy_s1, f2x_s1, f2y_s1;
	logic signed [DW-1:0] dot_s2 [4];
	logic [F-1:0] f2x_s2, f2y_s2, f3x_s2, f3y_s2;
	logic [WW-1:0] wx_s3, wy_s3, wy_s4, wy_s5;
	logic signed [DW-1:0] s_s3, u_s3;
	logic signed [DW:0] d1_s3, d2_s3;
	logic signed [LW-1:0] l1_s4, l2_s4, l1_s5;
	logic signed [LW:0] dn_s5;
	logic signed [NW-1:0] n_s6;
	logic signed [P1W-1:0] p1_s7;
	logic signed [PW-1:0] p2_s8;
	logic signed [gn2d_pkg::OUT_W-1:0] noise_s9;

	function automatic logic signed [SW-1:0] grad_sum(
		input logic [2:0] g,
		input logic signed [F:0] dx,
		input logic signed [F:0] dy
	);
		logic signed [SW-1:0] ex, ey, r;
		ex = SW'(dx);
		ey = SW'(dy);
		unique case (g)
			3'd0: r = ex + ey;
			3'd1: r = ey - ex;
			3'd2: r = ex - ey;
			3'd3: r = -ex - ey;
			3'd4: r = ex;
			3'd5: r = -ex;
			3'd6: r = ey;
			3'd7: r = -ey;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign adv = !vb_q[NB-1] || pop;
	assign q_pop = adv && !q_empty;
	assign empty = !vb_q[NB-1];
	assign noise_value = noise_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q <= '0;
		end else if (adv) begin
			vb_q <= {vb_q[NB-2:0], !q_empty};
		end
	end

	// corner offsets, gradient sums and squared fractions
	always_comb begin
		logic [F+1:0] tx, ty;
		logic signed [F:0] dx0, dx1, dy0, dy1;
		logic [2*F-1:0] px, py;
		tx = {2'b00, fx} - {2'b01, {F{1'b0}}};
		ty = {2'b00, fy} - {2'b01, {F{1'b0}}};
		dx0 = $signed({1'b0, fx});
		dy0 = $signed({1'b0, fy});
		dx1 = $signed(tx[F:0]);
		dy1 = $signed(ty[F:0]);
		sum_c[0] = grad_sum(corners.g00, dx0, dy0);
		sum_c[1] = grad_sum(corners.g10, dx1, dy0);
		sum_c[2] = grad_sum(corners.g01, dx0, dy1);
		sum_c[3] = grad_sum(corners.g11, dx1, dy1);
		diag_c[0] = !corners.g00[2];
		diag_c[1] = !corners.g10[2];
		diag_c[2] = !corners.g01[2];
		diag_c[3] = !corners.g11[2];
		px = {{F{1'b0}}, fx} * {{F{1'b0}}, fx};
		py = {{F{1'b0}}, fy} * {{F{1'b0}}, fy};
		f2x_c = px[2*F-1:F];
		f2y_c = py[2*F-1:F];
	end

	// dot products, rounded half up, and cubes
	always_comb begin
		logic signed [VW-1:0] v, vr;
		logic signed [VW-1:0] sh;
		logic [2*F-1:0] cx, cy;
		for (int k = 0; k < 4; k++) begin
			if (diag_s1[k]) begin
				v = sum_s1[k] * $signed({1'b0, 16'(gn2d_pkg::GRAD_DIAG)});
			end else begin
				v = VW'(sum_s1[k]) <<< gn2d_pkg::GRAD_SHIFT;
			end
			vr = v + $signed(VW'(32768));
			sh = vr >>> gn2d_pkg::GRAD_SHIFT;
			dot_c[k] = sh[DW-1:0];
		end
		cx = {{F{1'b0}}, f2x_s1} * {{F{1'b0}}, fx_s1};
		cy = {{F{1'b0}}, f2y_s1} * {{F{1'b0}}, fy_s1};
		f3x_c = cx[2*F-1:F];
		f3y_c = cy[2*F-1:F];
	end

	// fade weights
	always_comb begin
		wx_c = ({2'b00, f2x_s2} << 1) + {2'b00, f2x_s2} - ({2'b00, f3x_s2} << 1);
		wy_c = ({2'b00, f2y_s2} << 1) + {2'b00, f2y_s2} - ({2'b00, f3y_s2} << 1);
	end

	// lerps along x, then along y
	always_comb begin
		logic signed [2*F+5:0] pa, pb, ta, tb;
		logic signed [2*F+7:0] pc, tc;
		pa = $signed({1'b0, wx_s3}) * d1_s3;
		pb = $signed({1'b0, wx_s3}) * d2_s3;
		ta = (pa >>> F) + s_s3;
		tb = (pb >>> F) + u_s3;
		l1_c = ta[LW-1:0];
		l2_c = tb[LW-1:0];
		pc = $signed({1'b0, wy_s5}) * dn_s5;
		tc = (pc >>> F) + l1_s5;
		n_c = tc[NW-1:0];
	end

	// round half up and saturate
	always_comb begin
		logic signed [PW-1:0] rnd, rs, sh;
		logic signed [SHW-1:0] sv;
		rnd = PW'(1) <<< F;
		rs = p2_s8 + rnd;
		sh = rs >>> (F + 1);
		sv = sh[SHW-1:0];
		priority if (sv > SAT_HI) begin
			res_c = gn2d_pkg::OUT_W'(SAT_HI);
		end else if (sv < SAT_LO) begin
			res_c = gn2d_pkg::OUT_W'(SAT_LO);
		end else begin
			res_c = sv[gn2d_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= sum_c;
			diag_s1 <= diag_c;
			fx_s1 <= fx;
			fy_s1 <= fy;
			f2x_s1 <= f2x_c;
			f2y_s1 <= f2y_c;
			dot_s2 <= dot_c;
			f2x_s2 <= f2x_s1;
			f2y_s2 <= f2y_s1;
			f3x_s2 <= f3x_c;
			f3y_s2 <= f3y_c;
			wx_s3 <= wx_c;
			wy_s3 <= wy_c;
			s_s3 <= dot_s2[0];
			u_s3 <= dot_s2[2];
			d1_s3 <= (DW+1)'(dot_s2[1]) - (DW+1)'(dot_s2[0]);
			d2_s3 <= (DW+1)'(dot_s2[3]) - (DW+1)'(dot_s2[2]);
			l1_s4 <= l1_c;
			l2_s4 <= l2_c;
			wy_s4 <= wy_s3;
			l1_s5 <= l1_s4;
			dn_s5 <= (LW+1)'(l2_s4) - (LW+1)'(l1_s4);
			wy_s5 <= wy_s4;
			n_s6 <= n_c;
			p1_s7 <= n_s6 * $signed({1'b0, max_value});
			p2_s8 <= p1_s7 * $signed({1'b0, scale});
			noise_s9 <= res_c;
		end
	end

endmodule

// ===== rtl/gradient_noise_2d_core.sv =====
// channel   ports                                   request
// input     push, full, pixel_x, pixel_y            push & !full
// result    pop, empty, noise_value                 pop & !empty
// config    cfg_we, cfg_index, cfg_wdata            cfg_we
//
// one sample per clock sustained while pop is held; the front pipeline runs one restoring
// divider step per stage and the corner hashes, then the queue and back stages
// arst_n clears all valid state and loads the register defaults
// front and back stall separately, the four-entry queue between them absorbs stalls
// full rises only when the front's last stage holds a request and the queue is full
module gradient_noise_2d_core #(
	parameter int COORD_BITS = gn2d_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [gn2d_pkg::PIX_W-1:0]         pixel_x,
	input  logic [gn2d_pkg::PIX_W-1:0]         pixel_y,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [gn2d_pkg::OUT_W-1:0]  noise_value,
	input  logic                               cfg_we,
	input  logic [gn2d_pkg::IDX_W-1:0]         cfg_index,
	input  logic [gn2d_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int QW = gn2d_pkg::CORNER_W + 2 * FRAC_BITS;

	logic [gn2d_pkg::CFG_W-1:0] cell_size_q, scale_q;
	logic [gn2d_pkg::MAXV_W-1:0] max_value_q;
	logic q_full, q_push, q_empty, q_pop;
	logic [FRAC_BITS-1:0] ffx, ffy, bfx, bfy;
	gn2d_pkg::corner_t fcrn, bcrn;
	logic [QW-1:0] q_din, q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= gn2d_pkg::CELL_SIZE_RST;
			max_value_q <= gn2d_pkg::MAX_VALUE_RST;
			scale_q <= gn2d_pkg::SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gn2d_pkg::REG_CELL_SIZE: cell_size_q <= cfg_wdata;
				gn2d_pkg::REG_MAX_VALUE: max_value_q <= cfg_wdata[gn2d_pkg::MAXV_W-1:0];
				gn2d_pkg::REG_SCALE: scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	gn2d_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.full(full), .cell_size(cell_size_q), .q_full(q_full), .q_push(q_push),
		.fx(ffx), .fy(ffy), .corners(fcrn)
	);

	assign q_din = {fcrn, ffx, ffy};
	assign bcrn = q_dout[QW-1:2*FRAC_BITS];
	assign bfx = q_dout[2*FRAC_BITS-1:FRAC_BITS];
	assign bfy = q_dout[FRAC_BITS-1:0];

	gn2d_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(q_din), .full(q_full),
		.pop(q_pop), .dout(q_dout), .empty(q_empty)
	);

	gn2d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_pop(q_pop),
		.fx(bfx), .fy(bfy), .corners(bcrn), .max_value(max_value_q), .scale(scale_q),
		.empty(empty), .pop(pop), .noise_value(noise_value)
	);

endmodule

// ===== tb/sv/tb_gradient_noise_2d_core.sv =====
`timescale 1ns / 100ps

module tb_gradient_noise_2d_core;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [gn2d_pkg::PIX_W-1:0] pixel_x;
	logic [gn2d_pkg::PIX_W-1:0] pixel_y;
	logic empty;
	logic pop;
	logic signed [gn2d_pkg::OUT_W-1:0] noise_value;
	logic cfg_we;
	logic [gn2d_pkg::IDX_W-1:0] cfg_index;
	logic [gn2d_pkg::CFG_W-1:0] cfg_wdata;

	logic [15:0] cur_cell_size;
	logic [7:0] cur_max_value;
	logic [15:0] cur_scale;

	logic signed [gn2d_pkg::OUT_W-1:0] expected_noise[$];
	int errors;
	int idle_cycles;
	bit hold_pop;
	bit stall_mode;
	bit burst_mode;

	gradient_noise_2d_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.empty(empty),
		.pop(pop),
		.noise_value(noise_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint floor_div_pow2(longint v, int k);
		if (v >= 0)
			return v >>> k;
		return -((-(v + 1)) >>> k) - 1;
	endfunction

	function automatic logic [2:0] corner_hash(logic [7:0] i, logic [7:0] j);
		logic [7:0] inner;
		logic [7:0] idx;
		inner = gn2d_pkg::PERM[j];
		idx = i + inner;
		return gn2d_pkg::PERM[idx][2:0];
	endfunction

	function automatic longint corner_dot(logic [2:0] g, longint dx, longint dy);
		longint gx;
		longint gy;
		case (g)
			3'd0: begin gx = gn2d_pkg::GRAD_DIAG; gy = gn2d_pkg::GRAD_DIAG; end
			3'd1: begin gx = -gn2d_pkg::GRAD_DIAG; gy = gn2d_pkg::GRAD_DIAG; end
			3'd2: begin gx = gn2d_pkg::GRAD_DIAG; gy = -gn2d_pkg::GRAD_DIAG; end
			3'd3: begin gx = -gn2d_pkg::GRAD_DIAG; gy = -gn2d_pkg::GRAD_DIAG; end
			3'd4: begin gx = 65536; gy = 0; end
			3'd5: begin gx = -65536; gy = 0; end
			3'd6: begin gx = 0; gy = 65536; end
			default: begin gx = 0; gy = -65536; end
		endcase
		return floor_div_pow2(gx * dx + gy * dy + 32768, 16);
	endfunction

	function automatic longint fade_weight(longint f);
		longint f2;
		longint f3;
		f2 = (f * f) >> gn2d_pkg::FRAC_BITS_DEF;
		f3 = (f2 * f) >> gn2d_pkg::FRAC_BITS_DEF;
		return 3 * f2 - 2 * f3;
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a + floor_div_pow2(w * (b - a), gn2d_pkg::FRAC_BITS_DEF);
	endfunction

	function automatic logic signed [gn2d_pkg::OUT_W-1:0] predict_noise(logic [15:0] px,
		logic [15:0] py);
		longint c;
		longint one;
		longint fx;
		longint fy;
		logic [7:0] ci;
		logic [7:0] cj;
		longint s;
		longint t;
		longint u;
		longint v;
		longint wx;
		longint wy;
		longint n;
		longint res;
		c = (cur_cell_size == 0) ? 1 : cur_cell_size;
		one = longint'(1) << gn2d_pkg::FRAC_BITS_DEF;
		ci = 8'(longint'(px) / c);
		cj = 8'(longint'(py) / c);
		fx = ((longint'(px) % c) << gn2d_pkg::FRAC_BITS_DEF) / c;
		fy = ((longint'(py) % c) << gn2d_pkg::FRAC_BITS_DEF) / c;
		s = corner_dot(corner_hash(ci, cj), fx, fy);
		t = corner_dot(corner_hash(ci + 8'd1, cj), fx - one, fy);
		u = corner_dot(corner_hash(ci, cj + 8'd1), fx, fy - one);
		v = corner_dot(corner_hash(ci + 8'd1, cj + 8'd1), fx - one, fy - one);
		wx = fade_weight(fx);
		wy = fade_weight(fy);
		n = blend(blend(s, t, wx), blend(u, v, wx), wy);
		res = floor_div_pow2(n * longint'(cur_max_value) * longint'(cur_scale) + one,
			gn2d_pkg::FRAC_BITS_DEF + 1);
		if (res > 8388607)
			res = 8388607;
		if (res < -8388608)
			res = -8388608;
		return res[gn2d_pkg::OUT_W-1:0];
	endfunction

	task automatic write_reg(gn2d_pkg::reg_idx_t idx, logic [gn2d_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gn2d_pkg::REG_CELL_SIZE: cur_cell_size = val;
			gn2d_pkg::REG_MAX_VALUE: cur_max_value = val[7:0];
			gn2d_pkg::REG_SCALE: cur_scale = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(logic [15:0] cs, logic [7:0] mv, logic [15:0] sc);
		write_reg(gn2d_pkg::REG_CELL_SIZE, cs);
		write_reg(gn2d_pkg::REG_MAX_VALUE, {8'd0, mv});
		write_reg(gn2d_pkg::REG_SCALE, sc);
	endtask

	task automatic send_sample(logic [15:0] px, logic [15:0] py);
		push <= 1'b1;
		pixel_x <= px;
		pixel_y <= py;
		@(posedge clk);
		while (full)
			@(posedge clk);
		expected_noise.push_back(predict_noise(px, py));
	endtask

	task automatic pause_sender();
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (expected_noise.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random(int count, int pmax);
		int left;
		int gap;
		left = 0;
		for (int k = 0; k < count; k++) begin
			if (burst_mode && left == 0) begin
				left = $urandom_range(1, 20);
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if (left > 0)
				left--;
			if ($urandom_range(0, 9) == 0)
				send_sample(16'($urandom), 16'($urandom));
			else
				send_sample(16'($urandom_range(0, pmax)), 16'($urandom_range(0, pmax)));
		end
		pause_sender();
	endtask

	task automatic test_directed();
		logic [15:0] pts[12];
		pts = '{16'd0, 16'hFFFF, 16'd15, 16'd16, 16'd8, 16'd4095, 16'd4096,
			16'h5555, 16'hAAAA, 16'd1, 16'd255, 16'd256};
		for (int k = 0; k < 12; k++)
			send_sample(pts[k], pts[11 - k]);
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'd0, 16'hFFFF);
		wait_drained();
		configure(16'd0, 8'd255, 16'hFFFF);
		for (int k = 0; k < 6; k++)
			send_sample(pts[k], pts[k + 3]);
		wait_drained();
		configure(16'hFFFF, 8'd0, 16'd0);
		send_sample(16'hFFFE, 16'd1);
		send_sample(16'd32767, 16'hFFFF);
		wait_drained();
		write_reg(gn2d_pkg::reg_idx_t'(2'd3), 16'h1234);
		configure(16'd7, 8'd200, 16'd256);
		send_sample(16'd13, 16'd20);
		wait_drained();
	endtask

	task automatic test_random_settings();
		logic [15:0] sizes[6];
		sizes = '{16'd1, 16'd3, 16'd16, 16'd100, 16'd1000, 16'hFFFF};
		burst_mode = 1'b1;
		stall_mode = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			configure(sizes[ph], 8'($urandom_range(0, 255)), 16'($urandom));
			send_random(250, 2048);
			wait_drained();
		end
		configure(16'd16, 8'd255, 16'hFFFF);
		send_random(150, 65535);
		wait_drained();
	endtask

	task automatic test_backpressure();
		configure(16'd32, 8'd255, 16'd256);
		burst_mode = 1'b0;
		hold_pop = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_pop = 1'b0;
			end
			send_random(120, 65535);
		join
		wait_drained();
		stall_mode = 1'b0;
		send_random(80, 65535);
		wait_drained();
		stall_mode = 1'b1;
		burst_mode = 1'b1;
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else if (hold_pop)
			pop <= 1'b0;
		else if (stall_mode)
			pop <= ($urandom_range(0, 3) != 0);
		else
			pop <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_noise.size() == 0) begin
				errors++;
				$display("%0t: unexpected noise_value %0d", $time, noise_value);
			end else begin
				if (noise_value !== expected_noise[0]) begin
					errors++;
					$display("%0t: noise_value expected %0d actual %0d", $time,
						expected_noise[0], noise_value);
				end
				void'(expected_noise.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("gradient_noise_2d_core test failed");
			$finish;
		end
	end

	initial begin
		hold_pop = 1'b0;
		stall_mode = 1'b0;
		burst_mode = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		cfg_we = 1'b0;
		cfg_index = gn2d_pkg::REG_CELL_SIZE;
		cfg_wdata = '0;
		cur_cell_size = gn2d_pkg::CELL_SIZE_RST;
		cur_max_value = gn2d_pkg::MAX_VALUE_RST;
		cur_scale = gn2d_pkg::SCALE_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_backpressure();
		if (errors == 0 && expected_noise.size() == 0)
			$display("gradient_noise_2d_core test passed");
		else
			$display("gradient_noise_2d_core test failed");
		$finish;
	end

endmodule
